[rtl/core/ultrasonic_echo_ranger_macros.svh]
// -----------------------------------------------------------------------------
// ultrasonic_echo_ranger_macros.svh
// assertion macros shared by the ranger checker
// -----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define URNG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ultrasonic_echo_ranger: same-cycle check failed");

// next-cycle implication
`define URNG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ultrasonic_echo_ranger: next-cycle check failed");

`endif

[rtl/core/urng_pkg.sv]
// -----------------------------------------------------------------------------
// urng_pkg
// shared widths, register indexes and record types of the echo ranger
// -----------------------------------------------------------------------------
package urng_pkg;

  localparam int CountBits  = 17;               // echo width counter
  localparam int TrigW      = 8;
  localparam int TimeoutW   = 17;
  localparam int DistW      = 16;
  localparam int ScaleW     = 16;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 17;

  localparam logic [CfgIdxW-1:0] RegTriggerTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTimeoutTicks = 2'd1;
  localparam logic [CfgIdxW-1:0] RegThresholdMm  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSoundScale   = 2'd3;

  localparam logic [TrigW-1:0]    TriggerTicksRst = 8'd10;
  localparam logic [TimeoutW-1:0] TimeoutTicksRst = 17'd100000;
  localparam logic [DistW-1:0]    ThresholdRst    = 16'd200;
  localparam logic [ScaleW-1:0]   SoundScaleRst   = 16'd11239;

  typedef struct packed {
    logic [TrigW-1:0]    trigger_ticks;
    logic [TimeoutW-1:0] timeout_ticks;
    logic [DistW-1:0]    threshold_mm;
    logic [ScaleW-1:0]   sound_scale_q16;
  } cfg_t;

  typedef struct packed {
    logic             trigger_level;
    logic [DistW-1:0] distance_mm;
    logic             obstacle;
    logic             reading_done;
    logic             timed_out;
  } res_t;

endpackage

[rtl/core/urng_cfg.sv]
// -----------------------------------------------------------------------------
// urng_cfg
// configuration register file, written through a valid/ready channel
// -----------------------------------------------------------------------------
module urng_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [urng_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [urng_pkg::CfgDataW-1:0] cfg_data_i,
  output urng_pkg::cfg_t               cfg_o
);
  import urng_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegTriggerTicks: cfg_d.trigger_ticks   = cfg_data_i[TrigW-1:0];
        RegTimeoutTicks: cfg_d.timeout_ticks   = cfg_data_i[TimeoutW-1:0];
        RegThresholdMm:  cfg_d.threshold_mm    = cfg_data_i[DistW-1:0];
        RegSoundScale:   cfg_d.sound_scale_q16 = cfg_data_i[ScaleW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks   <= TriggerTicksRst;
      cfg_q.timeout_ticks   <= TimeoutTicksRst;
      cfg_q.threshold_mm    <= ThresholdRst;
      cfg_q.sound_scale_q16 <= SoundScaleRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/urng_ctrl.sv]
// -----------------------------------------------------------------------------
// urng_ctrl
// measurement sequencer: trigger, echo wait, width count, timeout, distance scaling
// -----------------------------------------------------------------------------
module urng_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tick_i,
  input  logic           echo_level_i,
  input  urng_pkg::cfg_t cfg_i,
  output urng_pkg::res_t res_o
);
  import urng_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhTrig = 2'd1;
  localparam logic [1:0] PhWait = 2'd2;
  localparam logic [1:0] PhMeas = 2'd3;

  localparam int ProdW = CountBits + ScaleW;
  localparam logic [DistW-1:0] MaxDist = '1;

  logic [1:0]           phase_q, phase_d;
  logic [TrigW-1:0]     trig_cnt_q, trig_cnt_d;
  logic [CountBits-1:0] width_q, width_d;
  logic [TimeoutW-1:0]  tout_cnt_q, tout_cnt_d;
  logic [DistW-1:0]     dist_q, dist_d;

  logic [ProdW-1:0]     prod;
  logic [CountBits-1:0] scaled;
  logic [DistW-1:0]     dist_sat;
  logic [TimeoutW-1:0]  limit;
  logic                 trig, done, tout;

  assign prod     = ProdW'(width_q) * ProdW'(cfg_i.sound_scale_q16);
  assign scaled   = prod[ProdW-1:ScaleW];
  assign dist_sat = (scaled > CountBits'(MaxDist)) ? MaxDist : DistW'(scaled);
  assign limit    = (cfg_i.timeout_ticks == '0) ? TimeoutW'(1) : cfg_i.timeout_ticks;

  always_comb begin
    phase_d    = phase_q;
    trig_cnt_d = trig_cnt_q;
    width_d    = width_q;
    tout_cnt_d = tout_cnt_q;
    dist_d     = dist_q;
    trig       = 1'b0;
    done       = 1'b0;
    tout       = 1'b0;
    case (phase_q)
      PhIdle: begin
        trig       = 1'b1;
        trig_cnt_d = TrigW'(1);
        tout_cnt_d = '0;
        width_d    = '0;
        phase_d    = PhTrig;
      end
      PhTrig: begin
        if (trig_cnt_q >= cfg_i.trigger_ticks) begin
          phase_d = PhWait;
        end else begin
          trig_cnt_d = trig_cnt_q + TrigW'(1);
          trig       = 1'b1;
        end
      end
      PhWait: begin
        if (echo_level_i) begin
          width_d = CountBits'(1);
          phase_d = PhMeas;
        end
      end
      PhMeas: begin
        if (echo_level_i) begin
          if (width_q != '1) width_d = width_q + CountBits'(1);
        end else begin
          dist_d  = dist_sat;
          done    = 1'b1;
          phase_d = PhIdle;
        end
      end
      default: phase_d = PhIdle;
    endcase
    // timeout runs on every non-idle tick unless a reading just finished
    if (phase_q != PhIdle && !done) begin
      if (tout_cnt_q != '1) tout_cnt_d = tout_cnt_q + TimeoutW'(1);
      if (tout_cnt_d >= limit) begin
        tout    = 1'b1;
        trig    = 1'b0;
        phase_d = PhIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      trig_cnt_q <= '0;
      width_q    <= '0;
      tout_cnt_q <= '0;
      dist_q     <= '0;
    end else if (tick_i) begin
      phase_q    <= phase_d;
      trig_cnt_q <= trig_cnt_d;
      width_q    <= width_d;
      tout_cnt_q <= tout_cnt_d;
      dist_q     <= dist_d;
    end
  end

  assign res_o.trigger_level = trig;
  assign res_o.distance_mm   = dist_d;
  assign res_o.obstacle      = dist_d < cfg_i.threshold_mm;
  assign res_o.reading_done  = done;
  assign res_o.timed_out     = tout;

endmodule

[rtl/core/urng_skid.sv]
// -----------------------------------------------------------------------------
// urng_skid
// result register with a skid entry, keeps the input side free of out stall
// -----------------------------------------------------------------------------
module urng_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  urng_pkg::res_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output urng_pkg::res_t out_data_o
);
  import urng_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic out_fire;

  assign out_fire = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/ultrasonic_echo_ranger.sv]
// -----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// ultrasonic range sensor driver, one input item per microsecond tick
// -----------------------------------------------------------------------------
// Each accepted tick yields exactly one registered result, and a new tick can be
// accepted every cycle while in_stall_o is low. The sequencer, a 17 x 16 bit scaling
// multiply and the threshold compare sit between the state registers and the result
// register; a skid entry behind the result register lets the input deliver one more
// result while the output stalls, so in_stall_o rises only after two results are waiting.
// Configuration writes are always accepted, as cfg_ready_o is tied high.
module ultrasonic_echo_ranger (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          echo_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          trigger_level_o,
  output logic [urng_pkg::DistW-1:0]    distance_mm_o,
  output logic                          obstacle_o,
  output logic                          reading_done_o,
  output logic                          timed_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [urng_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [urng_pkg::CfgDataW-1:0] cfg_data_i
);
  import urng_pkg::*;

  cfg_t cfg;
  res_t res, out_res;
  logic full;
  logic tick;

  assign in_stall_o = full;
  assign tick       = in_valid_i && !full;

  urng_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  urng_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .echo_level_i (echo_level_i),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  urng_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tick),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign trigger_level_o = out_res.trigger_level;
  assign distance_mm_o   = out_res.distance_mm;
  assign obstacle_o      = out_res.obstacle;
  assign reading_done_o  = out_res.reading_done;
  assign timed_out_o     = out_res.timed_out;

endmodule

[rtl/core/urng_checker.sv]
// -----------------------------------------------------------------------------
// urng_checker
// port-level checks of the echo ranger, bound to the top level
// -----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_macros.svh"

module urng_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       trigger_level_o,
  input logic [urng_pkg::DistW-1:0] distance_mm_o,
  input logic                       obstacle_o,
  input logic                       reading_done_o,
  input logic                       timed_out_o
);

  // a finished reading wins over the timeout
  `URNG_ASSERT_NOW(a_done_excl_tout, out_valid_o, !(reading_done_o && timed_out_o))

  // an abandoned measurement drops the trigger on that tick
  `URNG_ASSERT_NOW(a_tout_no_trig, out_valid_o && timed_out_o, !trigger_level_o)

  // a reading ends on the falling echo, long after the trigger pulse
  `URNG_ASSERT_NOW(a_done_no_trig, out_valid_o && reading_done_o, !trigger_level_o)

  // a stalled result holds
  `URNG_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(distance_mm_o) && $stable(obstacle_o))

endmodule

bind ultrasonic_echo_ranger urng_checker u_urng_checker (.*);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for ultrasonic_echo_ranger: echo ticks are streamed in
// under random handshake idling while a model of the trigger, echo timing and
// timeout sequence predicts every result, compared field by field
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import urng_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_PULSE, ST_AWAIT, ST_ECHO} ranger_state_e;

  localparam int unsigned RandomTicks = 300;
  localparam int          ProdW       = CountBits + ScaleW;
  localparam logic [CountBits-1:0] WidthMax   = '1;
  localparam logic [TimeoutW-1:0]  TimeoutMax = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                echo_level_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                trigger_level_o;
  logic [DistW-1:0]    distance_mm_o;
  logic                obstacle_o;
  logic                reading_done_o;
  logic                timed_out_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // ranging model state
  cfg_t                 model_cfg;
  ranger_state_e        model_state;
  logic [TrigW-1:0]     pulse_count;
  logic [CountBits-1:0] echo_count;
  logic [TimeoutW-1:0]  timeout_count;
  logic [DistW-1:0]     held_distance;

  res_t        tick_results_q[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent_ticks     = 0;
  int unsigned mismatches     = 0;

  ultrasonic_echo_ranger u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .echo_level_i   (echo_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trigger_level_o(trigger_level_o),
    .distance_mm_o  (distance_mm_o),
    .obstacle_o     (obstacle_o),
    .reading_done_o (reading_done_o),
    .timed_out_o    (timed_out_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic void predict_tick(input logic echo);
    res_t                 res;
    logic [ProdW-1:0]     product;
    logic [CountBits-1:0] scaled;
    logic [TimeoutW-1:0]  limit;
    res = '0;
    if (model_state == ST_IDLE) begin
      res.trigger_level = 1'b1;
      pulse_count       = TrigW'(1);
      timeout_count     = '0;
      echo_count        = '0;
      model_state       = ST_PULSE;
    end else begin
      case (model_state)
        ST_PULSE: begin
          if (pulse_count >= model_cfg.trigger_ticks) begin
            model_state = ST_AWAIT;
          end else begin
            pulse_count       = pulse_count + TrigW'(1);
            res.trigger_level = 1'b1;
          end
        end
        ST_AWAIT: begin
          if (echo) begin
            echo_count  = CountBits'(1);
            model_state = ST_ECHO;
          end
        end
        default: begin
          if (echo) begin
            if (echo_count != WidthMax) echo_count = echo_count + CountBits'(1);
          end else begin
            product = ProdW'(echo_count) * ProdW'(model_cfg.sound_scale_q16);
            scaled  = product[ProdW-1:16];
            held_distance    = (scaled[CountBits-1:DistW] != '0) ? '1 : scaled[DistW-1:0];
            res.reading_done = 1'b1;
            model_state      = ST_IDLE;
          end
        end
      endcase
      // a finished reading beats the timeout on the same tick
      if (!res.reading_done) begin
        limit = (model_cfg.timeout_ticks == '0) ? TimeoutW'(1) : model_cfg.timeout_ticks;
        if (timeout_count != TimeoutMax) timeout_count = timeout_count + TimeoutW'(1);
        if (timeout_count >= limit) begin
          res.timed_out     = 1'b1;
          res.trigger_level = 1'b0;
          model_state       = ST_IDLE;
        end
      end
    end
    res.distance_mm = held_distance;
    res.obstacle    = held_distance < model_cfg.threshold_mm;
    tick_results_q.push_back(res);
  endfunction

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tick_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result transfer with nothing expected, distance %0d",
                   $time, distance_mm_o);
        end
      end else begin
        want = tick_results_q.pop_front();
        if (trigger_level_o !== want.trigger_level || distance_mm_o !== want.distance_mm ||
            obstacle_o !== want.obstacle || reading_done_o !== want.reading_done ||
            timed_out_o !== want.timed_out) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected trig %b dist %0d obst %b done %b tout %b", $time,
                     want.trigger_level, want.distance_mm, want.obstacle,
                     want.reading_done, want.timed_out);
            $display("%0t: actual   trig %b dist %0d obst %b done %b tout %b", $time,
                     trigger_level_o, distance_mm_o, obstacle_o, reading_done_o,
                     timed_out_o);
          end
        end
      end
    end
  end

  task automatic send_tick(input logic echo);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    echo_level_i <= echo;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_tick(echo);
    sent_ticks++;
  endtask

  // hold the input until every outstanding result has been transferred
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [TrigW-1:0] trig, input logic [TimeoutW-1:0] tmo,
                                input logic [DistW-1:0] thr, input logic [ScaleW-1:0] scale);
    wait_idle();
    write_reg(RegTriggerTicks, CfgDataW'(trig));
    write_reg(RegTimeoutTicks, CfgDataW'(tmo));
    write_reg(RegThresholdMm, CfgDataW'(thr));
    write_reg(RegSoundScale, CfgDataW'(scale));
    cfg_valid_i <= 1'b0;
    model_cfg.trigger_ticks   = trig;
    model_cfg.timeout_ticks   = tmo;
    model_cfg.threshold_mm    = thr;
    model_cfg.sound_scale_q16 = scale;
  endtask

  // one ping: run out the trigger, then echo low for gap ticks, high for
  // high_len ticks and a falling tick
  task automatic echo_cycle(input int unsigned gap, input int unsigned high_len,
                            input bit noisy);
    int unsigned guard;
    guard = 0;
    while ((model_state == ST_IDLE || model_state == ST_PULSE) && guard < 64) begin
      send_tick(noisy && ($urandom_range(0, 1) == 1));
      guard++;
    end
    repeat (gap) send_tick(1'b0);
    repeat (high_len) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_reset_values();
    // reset registers; stored distance starts at zero so obstacle starts set
    echo_cycle(3, 6, 1'b1);
    echo_cycle(0, 20, 1'b0);
  endtask

  task automatic test_register_minimum();
    // zero trigger and zero timeout act as one
    apply_settings('0, '0, '0, '0);
    for (int i = 0; i < 6; i++) send_tick(i[0]);
    // zero scale stores distance zero, zero threshold clears obstacle
    apply_settings('0, TimeoutW'(40), '0, '0);
    echo_cycle(2, 4, 1'b1);
  endtask

  task automatic test_done_and_timeout();
    // falling tick lands on the timeout tick
    apply_settings(TrigW'(1), TimeoutW'(5), DistW'(3), ScaleW'(40000));
    echo_cycle(0, 3, 1'b0);
    // timeout one tick earlier abandons the measurement mid-echo
    apply_settings(TrigW'(1), TimeoutW'(4), DistW'(3), ScaleW'(40000));
    echo_cycle(0, 3, 1'b0);
  endtask

  task automatic test_timeout_in_pulse();
    apply_settings(TrigW'(20), TimeoutW'(6), DistW'(100), ScaleW'(65535));
    repeat (14) send_tick($urandom_range(0, 1) == 1);
  endtask

  task automatic test_random(input int unsigned ticks);
    int unsigned         stop_at;
    logic [TrigW-1:0]    trig;
    logic [TimeoutW-1:0] tmo;
    logic [DistW-1:0]    thr;
    stop_at = sent_ticks + ticks;
    while (sent_ticks < stop_at) begin
      trig = ($urandom_range(0, 9) == 0) ? TrigW'($urandom_range(0, 40))
                                         : TrigW'($urandom_range(1, 8));
      tmo  = ($urandom_range(0, 4) == 0) ? TimeoutW'($urandom_range(0, 12))
                                         : TimeoutW'(trig + $urandom_range(5, 60));
      thr  = ($urandom_range(0, 1) == 0) ? DistW'($urandom_range(0, 40))
                                         : DistW'($urandom_range(0, 65535));
      apply_settings(trig, tmo, thr, ScaleW'($urandom_range(0, 65535)));
      repeat ($urandom_range(2, 6)) begin
        if (sent_ticks < stop_at) begin
          case ($urandom_range(0, 9))
            0:       repeat ($urandom_range(1, 12)) send_tick($urandom_range(0, 1) == 1);
            1:       echo_cycle($urandom_range(0, 3), $urandom_range(40, 70), 1'b1);
            default: echo_cycle($urandom_range(0, 10), $urandom_range(1, 30),
                                $urandom_range(0, 1) == 1);
          endcase
        end
      end
    end
  endtask

  task automatic test_register_maximum();
    // full-scale timeout, threshold and scale
    apply_settings(TrigW'(3), '1, '1, '1);
    echo_cycle(1, 60, 1'b1);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    echo_level_i <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= RegTriggerTicks;
    cfg_data_i   <= '0;
    model_cfg     = '{trigger_ticks: TriggerTicksRst, timeout_ticks: TimeoutTicksRst,
                      threshold_mm: ThresholdRst, sound_scale_q16: SoundScaleRst};
    model_state   = ST_IDLE;
    pulse_count   = '0;
    echo_count    = '0;
    timeout_count = '0;
    held_distance = '0;
    set_idling(36, 81);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_register_minimum();
    test_done_and_timeout();
    test_timeout_in_pulse();
    test_random(RandomTicks / 3);
    set_idling(81, 36);
    test_random(RandomTicks / 3);
    set_idling(0, 0);
    test_random(RandomTicks / 3);
    test_register_maximum();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/urng_pkg.sv
rtl/core/urng_cfg.sv
rtl/core/urng_ctrl.sv
rtl/core/urng_skid.sv
rtl/core/ultrasonic_echo_ranger.sv
rtl/core/urng_checker.sv
bench/testbench.sv
